// File: rtl/core/tfc_pkg.sv
// Shared constants and types for the TCP flow counter table.
`timescale 1ns / 1ps

package tfc_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int COUNT_W           = 64;
    localparam int OUTCOME_W         = 2;

    localparam logic [7:0] TCP_PROTOCOL = 8'd6;

    localparam logic [OUTCOME_W-1:0] OUT_SKIPPED  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_COUNTED  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_INSERTED = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_FULL     = 2'd3;

    // Flow key: source address, destination address, ports (src high, dst low).
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] port_pair;
    } t_flow_key;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;   // an item is taken: latch the per-cell match
        logic track;  // the item is IPv4 TCP
        logic upd;    // update cycle: count on hit, insert if selected
        logic ins;    // no cell hit and the item is tracked
    } t_cell_ctl;

endpackage

// File: rtl/core/tfc_cell.sv
// One flow entry of the table: key, counter, valid mark and match logic.
`timescale 1ns / 1ps

module tfc_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tfc_pkg::t_cell_ctl           i_ctl,
    input  tfc_pkg::t_flow_key           i_key,
    input  tfc_pkg::t_flow_key           i_wr_key,
    input  logic                         i_prev_valid,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic [tfc_pkg::COUNT_W-1:0]  o_hit_count
);

    logic                        r_valid;
    logic                        r_hit;
    tfc_pkg::t_flow_key          r_key;
    logic [tfc_pkg::COUNT_W-1:0] r_count;
    logic [tfc_pkg::COUNT_W-1:0] n_count;
    logic                        ins_sel;

    // Entries fill in order, so the first free cell follows the last valid one.
    assign ins_sel = i_ctl.upd & i_ctl.ins & i_prev_valid & ~r_valid;
    assign n_count = r_count + tfc_pkg::COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_hit <= i_ctl.track & r_valid & (i_key == r_key);
            end else if (i_ctl.upd) begin
                r_hit <= 1'b0;
            end
            if (ins_sel) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && r_hit) begin
            r_count <= n_count;
        end else if (ins_sel) begin
            r_key   <= i_wr_key;
            r_count <= tfc_pkg::COUNT_W'(1);
        end
    end

    assign o_valid     = r_valid;
    assign o_hit       = r_hit;
    assign o_hit_count = r_hit ? n_count : '0;

endmodule

// File: rtl/core/tcp_flow_counter_table.sv
// Top level of the TCP flow counter table: sequencer, result register, cell row.
`timescale 1ns / 1ps
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  item in  | start, busy            | i_is_ipv4, i_ip_protocol, i_src_addr,
//           |                        | i_dst_addr, i_src_port, i_dst_port
//  item out | o_strobe (one cycle)   | o_outcome, o_flow_count
//
//  Each item has an accept step and an update step: the accept edge latches the
//  key and every cell's tag compare, the update edge updates the hit counter or
//  inserts the flow and registers the result; busy is high in that cycle only.
//  The result strobe is high in the cycle after the update; a new item can be
//  taken in that same cycle. The receiver cannot stall the output.
//  Reset (synchronous, active low) clears every valid mark and the sequencer.
//
module tcp_flow_counter_table #(
    parameter int TABLE_ENTRIES = tfc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_is_ipv4,
    input  logic [7:0]                     i_ip_protocol,
    input  logic [31:0]                    i_src_addr,
    input  logic [31:0]                    i_dst_addr,
    input  logic [15:0]                    i_src_port,
    input  logic [15:0]                    i_dst_port,
    output logic                           o_strobe,
    output logic [tfc_pkg::OUTCOME_W-1:0]  o_outcome,
    output logic [tfc_pkg::COUNT_W-1:0]    o_flow_count
);

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

    t_state                      r_state;
    logic                        r_track;
    tfc_pkg::t_flow_key          r_key;

    tfc_pkg::t_flow_key          live_key;
    tfc_pkg::t_cell_ctl          cell_ctl;
    logic                        accept;
    logic                        live_track;

    logic [TABLE_ENTRIES:0]      valid_chain;
    logic [TABLE_ENTRIES-1:0]    cell_hit;
    logic [tfc_pkg::COUNT_W-1:0] cell_count [TABLE_ENTRIES];
    logic                        any_hit;
    logic [tfc_pkg::COUNT_W-1:0] hit_count;
    logic                        table_full;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start & ~busy;
    assign live_track = i_is_ipv4 & (i_ip_protocol == tfc_pkg::TCP_PROTOCOL);

    assign live_key.src_addr  = i_src_addr;
    assign live_key.dst_addr  = i_dst_addr;
    assign live_key.port_pair = {i_src_port, i_dst_port};

    // Cell 0 always sees a valid neighbor, so it is the first free one when empty.
    assign valid_chain[0] = 1'b1;
    assign table_full     = valid_chain[TABLE_ENTRIES];

    // A flow lives in at most one cell, so a plain OR picks the hit counter.
    always_comb begin
        hit_count = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_count = hit_count | cell_count[i];
        end
    end
    assign any_hit = |cell_hit;

    assign cell_ctl.load  = accept;
    assign cell_ctl.track = live_track;
    assign cell_ctl.upd   = (r_state == S_UPD);
    assign cell_ctl.ins   = r_track & ~any_hit;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            tfc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (cell_ctl),
                .i_key        (live_key),
                .i_wr_key     (r_key),
                .i_prev_valid (valid_chain[g]),
                .o_valid      (valid_chain[g+1]),
                .o_hit        (cell_hit[g]),
                .o_hit_count  (cell_count[g])
            );
        end
    endgenerate

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    o_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                    // Resolve the outcome from the compare latched at accept.
                    if (!r_track) begin
                        o_outcome    <= tfc_pkg::OUT_SKIPPED;
                        o_flow_count <= '0;
                    end else if (any_hit) begin
                        o_outcome    <= tfc_pkg::OUT_COUNTED;
                        o_flow_count <= hit_count;
                    end else if (!table_full) begin
                        o_outcome    <= tfc_pkg::OUT_INSERTED;
                        o_flow_count <= tfc_pkg::COUNT_W'(1);
                    end else begin
                        o_outcome    <= tfc_pkg::OUT_FULL;
                        o_flow_count <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Hold the item's key for the update cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_track <= live_track;
            r_key   <= live_key;
        end
    end

endmodule
